// ===== hw/rtl/dot_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the dark object crossing timer
// no dependencies
package dot_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int TIME_W     = 48;
  localparam int BRIGHT_W   = 8;
  localparam int ENTRY_W    = TIME_W + BRIGHT_W;
  localparam int DIV_W      = TIME_W + BRIGHT_W;
  localparam int CONF_W     = 9;
  localparam int CFG_IDX_W  = 4;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ENTERING = 2'd1,
    PH_PRESENT  = 2'd2,
    PH_EXITING  = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE = 4'd0,
    REG_DROP     = 4'd1,
    REG_CONFIRM  = 4'd2,
    REG_CLEAR    = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] frame_brightness;
    logic [TIME_W-1:0]   frame_time_us;
  } dot_in_t;

  typedef struct packed {
    logic                detected;
    logic [TIME_W-1:0]   cross_time;
    logic [CONF_W-1:0]   confidence_q8;
    logic [1:0]          detector_phase;
  } dot_out_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] bright;
    logic [TIME_W-1:0]   stamp;
  } ring_entry_t;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [BRIGHT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/dot_ring_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module dot_ring_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dot_divider.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, narrow divisor
// depends on dot_pkg
module dot_divider (
  input  logic              clk,
  input  logic              rst,
  input  dot_pkg::div_req_t req,
  output dot_pkg::div_rsp_t rsp
);
  import dot_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    dvd;
  logic [BRIGHT_W-1:0] rem;
  logic [BRIGHT_W-1:0] dvs;
  logic                done;
  logic [BRIGHT_W:0]   shifted;
  logic                take;

  assign shifted = {rem, dvd[DIV_W-1]};
  assign take    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(DIV_W);
        dvd <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
      end else if (cnt != '0) begin
        rem <= take ? BRIGHT_W'(shifted - {1'b0, dvs}) : shifted[BRIGHT_W-1:0];
        dvd <= {dvd[DIV_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd[TIME_W-1:0];

endmodule

// ===== hw/rtl/dark_object_crossing_timer.sv =====
`timescale 1ns / 1ps
// dark object crossing timer: frame history ring in ram, debounce, crossing interpolation
// depends on dot_pkg, dot_ring_ram, dot_divider
// flow: an unconfirmed frame is held in the result stage, then taken by the output register
//   when it is free; a confirming frame walks the ring (unless it is short) for its minimum, then
//   scans back from the newest slot, and a crossing pair found there adds a multiply and a serial
//   divide before the finish state. throughput: one frame at a time, since the held result stalls
//   the input until the output register takes it; a confirmation stalls it throughout
// reset: phase idle, counts and ring pointers zero, registers at their documented defaults
module dark_object_crossing_timer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dot_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dot_pkg::BRIGHT_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dot_pkg::dot_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dot_pkg::dot_out_t                out_data
);
  import dot_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MIN, S_SCAN, S_MUL, S_DIV, S_FINISH
  } state_t;

  // configuration registers
  logic [BRIGHT_W-1:0] baseline_level, drop_threshold, confirm_frames, clear_frames;

  // debounce and ring bookkeeping
  phase_t              phase;
  logic [7:0]          frames_in_phase;
  logic [IDX_W-1:0]    ring_idx;
  logic [FILL_W-1:0]   ring_fill;

  // sequencer
  state_t              state;
  logic [FILL_W-1:0]   ptr;
  logic [FILL_W-1:0]   dk;
  logic                dv;
  logic [BRIGHT_W-1:0] lo;
  logic [BRIGHT_W-1:0] mid;
  logic [BRIGHT_W-1:0] prev_b;
  logic [TIME_W-1:0]   prev_t;
  logic [TIME_W-1:0]   newest_t;
  logic [TIME_W-1:0]   oldest_t;
  logic                have_present;
  logic [TIME_W-1:0]   tp, tc;
  logic [BRIGHT_W-1:0] num_b, den_b;
  logic [DIV_W-1:0]    prod;
  logic [TIME_W-1:0]   ctime;
  phase_t              res_phase;

  // confidence: 8 step serial divide of drop<<8 by baseline
  logic [3:0]          conf_cnt;
  logic [BRIGHT_W-1:0] conf_rem;
  logic [BRIGHT_W-1:0] conf_q;
  logic [BRIGHT_W:0]   conf_sh;
  logic                conf_take;
  logic                conf_full;

  // result holding stage and output register
  logic                res_valid;
  dot_out_t            res;

  // ram ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  ring_entry_t         ram_wentry, ram_rentry;
  logic [ENTRY_W-1:0]  ram_rdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // accept-time combinational work
  logic                in_acc;
  logic [BRIGHT_W-1:0] b_in;
  logic                now_present;
  logic [FILL_W-1:0]   fill_inc;
  logic [IDX_W-1:0]    idx_inc;
  logic [7:0]          cnt_inc;
  logic                confirm;

  // scan-time combinational work
  logic [BRIGHT_W-1:0] rd_b;
  logic [TIME_W-1:0]   rd_t;
  logic [BRIGHT_W-1:0] lo_new;
  logic                rd_present;
  logic                pair_hit;
  logic                last_data;

  function automatic logic present_test(input logic [BRIGHT_W-1:0] b,
                                        input logic [BRIGHT_W-1:0] base,
                                        input logic [BRIGHT_W-1:0] thr);
    logic [BRIGHT_W-1:0] d;
    d = base - b;
    return (b < base) && (d >= thr);
  endfunction

  assign in_acc      = in_valid && !in_stall;
  assign in_stall    = (state != S_IDLE) || res_valid;
  assign b_in        = in_data.frame_brightness;
  assign now_present = present_test(b_in, baseline_level, drop_threshold);
  assign fill_inc    = (ring_fill < FILL_W'(RING_DEPTH)) ? ring_fill + 1'b1 : ring_fill;
  assign idx_inc     = ring_idx + 1'b1;
  assign cnt_inc     = (frames_in_phase != 8'hff) ? frames_in_phase + 1'b1 : frames_in_phase;
  assign confirm     = (phase == PH_ENTERING) && now_present && (cnt_inc >= confirm_frames);

  // frame write lands on the accept edge, so the walks that follow see it
  assign ram_we           = in_acc;
  assign ram_wentry.bright = b_in;
  assign ram_wentry.stamp  = in_data.frame_time_us;

  // min walk reads slots in order; scan walks back from the newest slot
  always_comb begin
    if (state == S_SCAN) begin
      ram_raddr = ring_idx - ptr[IDX_W-1:0] - 1'b1;
    end else begin
      ram_raddr = ptr[IDX_W-1:0];
    end
  end

  assign ram_rentry = ram_rdata;
  assign rd_b       = ram_rentry.bright;
  assign rd_t       = ram_rentry.stamp;
  assign lo_new     = (rd_b < lo) ? rd_b : lo;
  assign rd_present = present_test(rd_b, baseline_level, drop_threshold);
  assign pair_hit   = (dk != '0) && (rd_b >= mid) && (prev_b < mid);
  assign last_data  = dv && (dk == ring_fill - 1'b1);

  assign conf_sh   = {conf_rem, 1'b0};
  assign conf_take = conf_sh >= {1'b0, baseline_level};

  dot_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_idx),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dot_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_level <= '0;
      drop_threshold <= '0;
      confirm_frames <= 8'd3;
      clear_frames   <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASELINE: baseline_level <= cfg_data;
        REG_DROP:     drop_threshold <= cfg_data;
        REG_CONFIRM:  confirm_frames <= cfg_data;
        REG_CLEAR:    clear_frames   <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_IDLE;
      frames_in_phase <= '0;
      ring_idx        <= '0;
      ring_fill       <= '0;
      res_valid       <= 1'b0;
      out_valid       <= 1'b0;
      conf_cnt        <= '0;
      dv              <= 1'b0;
      div_req.start   <= 1'b0;
    end else begin
      div_req.start <= 1'b0;

      // confidence loop runs alongside the ring walks
      if (conf_cnt != '0) begin
        conf_rem <= conf_take ? BRIGHT_W'(conf_sh - {1'b0, baseline_level})
                              : conf_sh[BRIGHT_W-1:0];
        conf_q   <= {conf_q[BRIGHT_W-2:0], conf_take};
        conf_cnt <= conf_cnt - 1'b1;
      end

      // output register takes the held result when free
      if (res_valid && (!out_valid || !out_stall)) begin
        out_data  <= res;
        out_valid <= 1'b1;
        res_valid <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            ring_idx  <= idx_inc;
            ring_fill <= fill_inc;
            newest_t  <= in_data.frame_time_us;
            res.detected      <= 1'b0;
            res.cross_time    <= '0;
            res.confidence_q8 <= '0;
            res_valid         <= !confirm;
            case (phase)
              PH_IDLE: begin
                if (now_present) begin
                  phase           <= PH_ENTERING;
                  frames_in_phase <= 8'd1;
                end
              end
              PH_ENTERING: begin
                if (now_present) begin
                  if (confirm) begin
                    phase           <= PH_PRESENT;
                    frames_in_phase <= '0;
                  end else begin
                    frames_in_phase <= cnt_inc;
                  end
                end else begin
                  phase           <= PH_IDLE;
                  frames_in_phase <= '0;
                end
              end
              PH_PRESENT: begin
                if (!now_present) begin
                  phase           <= PH_EXITING;
                  frames_in_phase <= 8'd1;
                end
              end
              default: begin
                if (!now_present) begin
                  if (cnt_inc >= clear_frames) begin
                    phase           <= PH_IDLE;
                    frames_in_phase <= '0;
                    ring_idx        <= '0;
                    ring_fill       <= '0;
                  end else begin
                    frames_in_phase <= cnt_inc;
                  end
                end else begin
                  phase           <= PH_PRESENT;
                  frames_in_phase <= '0;
                end
              end
            endcase
            res.detector_phase <= confirm ? PH_PRESENT :
                                  (phase == PH_IDLE && now_present) ? PH_ENTERING :
                                  (phase == PH_ENTERING) ?
                                    (now_present ? PH_ENTERING : PH_IDLE) :
                                  (phase == PH_PRESENT && !now_present) ? PH_EXITING :
                                  (phase == PH_EXITING && !now_present) ?
                                    ((cnt_inc >= clear_frames) ? PH_IDLE : PH_EXITING) :
                                  (phase == PH_EXITING) ? PH_PRESENT : phase;
            if (confirm) begin
              res_phase    <= PH_PRESENT;
              conf_rem     <= baseline_level - b_in;
              conf_q       <= '0;
              conf_cnt     <= 4'd8;
              // a fully dark frame is a full-scale drop
              conf_full    <= (b_in == '0);
              lo           <= 8'hff;
              ptr          <= '0;
              dv           <= 1'b0;
              have_present <= 1'b0;
              ctime        <= in_data.frame_time_us;
              // a short ring reports the newest frame directly
              state        <= (fill_inc < FILL_W'(2)) ? S_FINISH : S_MIN;
            end
          end
        end
        S_MIN: begin
          dv <= ptr < ring_fill;
          if (ptr < ring_fill) begin
            ptr <= ptr + 1'b1;
          end
          if (dv) begin
            lo <= lo_new;
          end
          if (dv && ptr == ring_fill) begin
            mid   <= BRIGHT_W'(({1'b0, baseline_level} + {1'b0, lo_new}) >> 1);
            ptr   <= '0;
            dv    <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          dv <= ptr < ring_fill;
          dk <= ptr;
          if (ptr < ring_fill) begin
            ptr <= ptr + 1'b1;
          end
          if (dv) begin
            prev_b <= rd_b;
            prev_t <= rd_t;
            if (rd_present) begin
              oldest_t     <= rd_t;
              have_present <= 1'b1;
            end
            if (pair_hit) begin
              tp    <= rd_t;
              tc    <= prev_t;
              num_b <= rd_b - mid;
              den_b <= rd_b - prev_b;
              dv    <= 1'b0;
              state <= S_MUL;
            end else if (last_data) begin
              ctime <= rd_present ? rd_t : (have_present ? oldest_t : newest_t);
              dv    <= 1'b0;
              state <= S_FINISH;
            end
          end
        end
        S_MUL: begin
          // full 56 bit product of the brightness step and the time step
          prod          <= DIV_W'(num_b) * DIV_W'((tc > tp) ? tc - tp : TIME_W'(0));
          state         <= S_DIV;
          div_req.start <= 1'b1;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            ctime <= tp + div_rsp.quotient;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // wait for the confidence loop before releasing the result
          if (conf_cnt == '0) begin
            res.detected       <= 1'b1;
            res.cross_time     <= ctime;
            res.confidence_q8  <= (baseline_level == '0) ? '0 :
                                  conf_full ? CONF_W'(256) : {1'b0, conf_q};
            res.detector_phase <= res_phase;
            res_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operands go out the cycle the start pulse is raised
  assign div_req.dividend = prod;
  assign div_req.divisor  = den_b;

  a_detect_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.detected |-> out_data.detector_phase == PH_PRESENT)
    else $error("detection reported outside present phase");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.detected |->
      out_data.cross_time == '0 && out_data.confidence_q8 == '0)
    else $error("non detecting result carries time or confidence");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FILL_W'(RING_DEPTH))
    else $error("ring fill beyond depth");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !(in_valid && !in_stall))
    else $error("frame taken while a crossing is being computed");

endmodule
